// ----- design/qslerp_pkg.sv -----
// Shared types, constants and the arctangent table for the quaternion slerp pipeline.
// No dependencies; every other file in this folder imports it.
package qslerp_pkg;

	localparam logic [28:0] ONE_Q28 = 29'h1000_0000;
	localparam logic signed [33:0] DOT_ONE = 34'sh1000_0000;
	localparam logic signed [31:0] HALF_PI_Q30 = 32'sd1686629713;
	localparam logic [15:0] FRAC_ONE = 16'h8000;
	localparam logic [33:0] RATIO_LIM = 34'h1_0000_0000;
	localparam logic signed [51:0] ROUND_Q27 = 52'sh800_0000;

	typedef enum logic [1:0] {
		PATH_COPY  = 2'd0,
		PATH_MEAN  = 2'd1,
		PATH_BLEND = 2'd2
	} path_t;

	// Per-item payload that rides alongside the arithmetic units.
	typedef struct packed {
		logic [3:0][15:0] st;
		logic [3:0][16:0] fin;
		logic [15:0]      frac;
		logic [3:0][15:0] fb;
		path_t            fb_path;
		logic             big;
	} item_t;

	typedef struct packed {
		logic [27:0] c;
		item_t       it;
	} sq_sb_t;

	typedef struct packed {
		logic  try_blend;
		item_t it;
	} vec_sb_t;

	typedef struct packed {
		logic       blend;
		logic [1:0] neg;
		item_t      it;
	} div_sb_t;

	// atan(2^-i) in Q.30 radians.
	function automatic logic signed [31:0] atan_q30(input int idx);
		logic signed [31:0] r;
		case (idx)
			0: r = 32'sh3243F6A8;
			1: r = 32'sh1DAC6705;
			2: r = 32'sh0FADBAFC;
			3: r = 32'sh07F56EA6;
			4: r = 32'sh03FEAB76;
			5: r = 32'sh01FFD55B;
			6: r = 32'sh00FFFAAA;
			7: r = 32'sh007FFF55;
			8: r = 32'sh003FFFEA;
			9: r = 32'sh001FFFFD;
			10: r = 32'sh000FFFFF;
			11: r = 32'sh0007FFFF;
			12: r = 32'sh0003FFFF;
			13: r = 32'sh0001FFFF;
			14: r = 32'sh0000FFFF;
			15: r = 32'sh00007FFF;
			16: r = 32'sh00003FFF;
			17: r = 32'sh00001FFF;
			18: r = 32'sh00000FFF;
			19: r = 32'sh000007FF;
			20: r = 32'sh000003FF;
			21: r = 32'sh000001FF;
			22: r = 32'sh000000FF;
			23: r = 32'sh0000007F;
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic [15:0] sat16(input logic signed [23:0] v);
		logic [15:0] r;
		if (v > 24'sd32767) begin
			r = 16'h7FFF;
		end else if (v < -24'sd32768) begin
			r = 16'h8000;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

endpackage

// ----- design/qslerp_sqrt.sv -----
// Pipelined restoring square root of rad * 2^28, one result bit per stage.
// Depends on qslerp_pkg.
module qslerp_sqrt #(
	parameter int SB_W = 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  logic [28:0]     rad,
	input  logic [SB_W-1:0] sb_in,
	output logic            out_valid,
	output logic [28:0]     root,
	output logic [SB_W-1:0] sb_out
);
	import qslerp_pkg::*;

	localparam int STEPS = 29;

	logic            vld_s  [STEPS];
	logic [28:0]     rad_s  [STEPS];
	logic [28:0]     root_s [STEPS];
	logic [31:0]     rem_s  [STEPS];
	logic [SB_W-1:0] sb_s   [STEPS];

	for (genvar j = 0; j < STEPS; j++) begin : g_step
		localparam int BIT = STEPS - 1 - j;
		logic            vi;
		logic [28:0]     radi, rooti;
		logic [31:0]     remi, rem_sh, trial;
		logic [57:0]     v;
		logic [SB_W-1:0] sbi;

		if (j == 0) begin : g_first
			assign vi    = in_valid;
			assign radi  = rad;
			assign rooti = '0;
			assign remi  = '0;
			assign sbi   = sb_in;
		end else begin : g_next
			assign vi    = vld_s[j-1];
			assign radi  = rad_s[j-1];
			assign rooti = root_s[j-1];
			assign remi  = rem_s[j-1];
			assign sbi   = sb_s[j-1];
		end

		assign v      = {1'b0, radi, 28'b0};
		assign rem_sh = {remi[29:0], v[2*BIT+1 -: 2]};
		assign trial  = {1'b0, rooti, 2'b01};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else if (en) begin
				vld_s[j] <= vi;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[j] <= radi;
				sb_s[j]  <= sbi;
				if (rem_sh >= trial) begin
					rem_s[j]  <= rem_sh - trial;
					root_s[j] <= {rooti[27:0], 1'b1};
				end else begin
					rem_s[j]  <= rem_sh;
					root_s[j] <= {rooti[27:0], 1'b0};
				end
			end
		end
	end

	assign out_valid = vld_s[STEPS-1];
	assign root      = root_s[STEPS-1];
	assign sb_out    = sb_s[STEPS-1];

endmodule

// ----- design/qslerp_cordic_vec.sv -----
// Pipelined CORDIC in vectoring mode: accumulates the angle of (x, y), one step per stage.
// Depends on qslerp_pkg for the arctangent table.
module qslerp_cordic_vec #(
	parameter int N    = 16,
	parameter int SB_W = 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  logic signed [31:0] x_in,
	input  logic signed [31:0] y_in,
	input  logic [SB_W-1:0]    sb_in,
	output logic               out_valid,
	output logic signed [31:0] ang_out,
	output logic [SB_W-1:0]    sb_out
);
	import qslerp_pkg::*;

	logic               vld_s [N];
	logic signed [31:0] x_s   [N];
	logic signed [31:0] y_s   [N];
	logic signed [31:0] z_s   [N];
	logic [SB_W-1:0]    sb_s  [N];

	for (genvar i = 0; i < N; i++) begin : g_step
		localparam logic signed [31:0] ANG = atan_q30(i);
		logic               vi;
		logic signed [31:0] xi, yi, zi;
		logic [SB_W-1:0]    sbi;

		if (i == 0) begin : g_first
			assign vi  = in_valid;
			assign xi  = x_in;
			assign yi  = y_in;
			assign zi  = '0;
			assign sbi = sb_in;
		end else begin : g_next
			assign vi  = vld_s[i-1];
			assign xi  = x_s[i-1];
			assign yi  = y_s[i-1];
			assign zi  = z_s[i-1];
			assign sbi = sb_s[i-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (en) begin
				vld_s[i] <= vi;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sb_s[i] <= sbi;
				if (yi > 0) begin
					x_s[i] <= xi + (yi >>> i);
					y_s[i] <= yi - (xi >>> i);
					z_s[i] <= zi + ANG;
				end else begin
					x_s[i] <= xi - (yi >>> i);
					y_s[i] <= yi + (xi >>> i);
					z_s[i] <= zi - ANG;
				end
			end
		end
	end

	assign out_valid = vld_s[N-1];
	assign ang_out   = z_s[N-1];
	assign sb_out    = sb_s[N-1];

endmodule

// ----- design/qslerp_cordic_rot.sv -----
// Pipelined CORDIC in rotation mode over several angle lanes, returning the scaled sines.
// Depends on qslerp_pkg for the arctangent table and the unit constant.
module qslerp_cordic_rot #(
	parameter int N     = 16,
	parameter int LANES = 3,
	parameter int SB_W  = 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  logic signed [31:0] ang_in [LANES],
	input  logic [SB_W-1:0]    sb_in,
	output logic               out_valid,
	output logic signed [31:0] sin_out [LANES],
	output logic [SB_W-1:0]    sb_out
);
	import qslerp_pkg::*;

	logic               vld_s [N];
	logic signed [31:0] x_s   [N][LANES];
	logic signed [31:0] y_s   [N][LANES];
	logic signed [31:0] z_s   [N][LANES];
	logic [SB_W-1:0]    sb_s  [N];

	for (genvar i = 0; i < N; i++) begin : g_step
		localparam logic signed [31:0] ANG = atan_q30(i);
		logic            vi;
		logic [SB_W-1:0] sbi;

		if (i == 0) begin : g_first
			assign vi  = in_valid;
			assign sbi = sb_in;
		end else begin : g_next
			assign vi  = vld_s[i-1];
			assign sbi = sb_s[i-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (en) begin
				vld_s[i] <= vi;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sb_s[i] <= sbi;
			end
		end

		for (genvar l = 0; l < LANES; l++) begin : g_lane
			logic signed [31:0] xi, yi, zi;

			if (i == 0) begin : g_first
				assign xi = 32'($signed({3'b0, ONE_Q28}));
				assign yi = '0;
				assign zi = ang_in[l];
			end else begin : g_next
				assign xi = x_s[i-1][l];
				assign yi = y_s[i-1][l];
				assign zi = z_s[i-1][l];
			end

			always_ff @(posedge clk) begin
				if (en) begin
					if (zi >= 0) begin
						x_s[i][l] <= xi - (yi >>> i);
						y_s[i][l] <= yi + (xi >>> i);
						z_s[i][l] <= zi - ANG;
					end else begin
						x_s[i][l] <= xi + (yi >>> i);
						y_s[i][l] <= yi - (xi >>> i);
						z_s[i][l] <= zi + ANG;
					end
				end
			end
		end
	end

	for (genvar l = 0; l < LANES; l++) begin : g_out
		assign sin_out[l] = y_s[N-1][l];
	end

	assign out_valid = vld_s[N-1];
	assign sb_out    = sb_s[N-1];

endmodule

// ----- design/qslerp_div.sv -----
// Pipelined restoring divider forming (num * 2^28) / den over several lanes, one bit per stage.
// The quotient covers 34 bits; a larger one is flagged as overflow. Depends on qslerp_pkg.
module qslerp_div #(
	parameter int LANES = 2,
	parameter int SB_W  = 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  logic [28:0]     num_in [LANES],
	input  logic [28:0]     den_in,
	input  logic [SB_W-1:0] sb_in,
	output logic            out_valid,
	output logic [33:0]     quo_out [LANES],
	output logic            ovf_out [LANES],
	output logic [SB_W-1:0] sb_out
);
	import qslerp_pkg::*;

	localparam int STEPS = 34;

	logic            vld_s [STEPS];
	logic [28:0]     den_s [STEPS];
	logic [SB_W-1:0] sb_s  [STEPS];
	logic [28:0]     num_s [STEPS][LANES];
	logic [29:0]     rem_s [STEPS][LANES];
	logic [33:0]     quo_s [STEPS][LANES];
	logic            ovf_s [STEPS][LANES];

	for (genvar j = 0; j < STEPS; j++) begin : g_step
		localparam int K = STEPS - 1 - j;
		logic            vi;
		logic [28:0]     deni;
		logic [SB_W-1:0] sbi;

		if (j == 0) begin : g_first
			assign vi   = in_valid;
			assign deni = den_in;
			assign sbi  = sb_in;
		end else begin : g_next
			assign vi   = vld_s[j-1];
			assign deni = den_s[j-1];
			assign sbi  = sb_s[j-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else if (en) begin
				vld_s[j] <= vi;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				den_s[j] <= deni;
				sb_s[j]  <= sbi;
			end
		end

		for (genvar l = 0; l < LANES; l++) begin : g_lane
			logic [28:0] numi;
			logic [29:0] remi, rem_sh;
			logic [33:0] quoi;
			logic        ovfi, nb;

			if (j == 0) begin : g_first
				assign numi = num_in[l];
				assign remi = {7'b0, num_in[l][28:6]};
				assign quoi = '0;
				assign ovfi = {6'b0, num_in[l][28:6]} >= den_in;
			end else begin : g_next
				assign numi = num_s[j-1][l];
				assign remi = rem_s[j-1][l];
				assign quoi = quo_s[j-1][l];
				assign ovfi = ovf_s[j-1][l];
			end

			if (K >= 28) begin : g_num_bit
				assign nb = numi[K-28];
			end else begin : g_zero_bit
				assign nb = 1'b0;
			end

			assign rem_sh = {remi[28:0], nb};

			always_ff @(posedge clk) begin
				if (en) begin
					num_s[j][l] <= numi;
					ovf_s[j][l] <= ovfi;
					if (rem_sh >= {1'b0, deni}) begin
						rem_s[j][l] <= rem_sh - {1'b0, deni};
						quo_s[j][l] <= {quoi[32:0], 1'b1};
					end else begin
						rem_s[j][l] <= rem_sh;
						quo_s[j][l] <= {quoi[32:0], 1'b0};
					end
				end
			end
		end
	end

	for (genvar l = 0; l < LANES; l++) begin : g_out
		assign quo_out[l] = quo_s[STEPS-1][l];
		assign ovf_out[l] = ovf_s[STEPS-1][l];
	end

	assign out_valid = vld_s[STEPS-1];
	assign sb_out    = sb_s[STEPS-1];

endmodule

// ----- design/quaternion_slerp_unit.sv -----
// The pipe holds the 29-stage square root, the two CORDIC chains and the 34-stage divider.
// Throughput: one item per cycle; every unit is fully pipelined and the whole pipe
// advances whenever the output register is empty or being taken.
// Reset (arst_n low, asynchronous) clears all valid bits and sets small_angle_limit to 16.
// Depends on qslerp_pkg, qslerp_sqrt, qslerp_cordic_vec, qslerp_cordic_rot and qslerp_div.
module quaternion_slerp_unit #(
	parameter int TRIG_ITERATIONS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// start_w, start_x, start_y, start_z, end_w, end_x, end_y, end_z, blend_fraction
	input  logic [143:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// out_w, out_x, out_y, out_z
	output logic [63:0]  m_tdata,
	// path_taken
	output logic [1:0]   m_tuser,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	// small_angle_limit
	input  logic [14:0]  cfg_data
);
	import qslerp_pkg::*;

	// The whole pipeline moves together. When the output register holds a result that
	// the sink is not taking, every stage holds, so nothing is dropped or repeated.
	logic adv;
	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;

	// The threshold register accepts a transfer in any cycle.
	logic [14:0] lim_q;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_q <= 15'd16;
		end else if (cfg_valid) begin
			lim_q <= cfg_data;
		end
	end

	// Stage 1: capture the operands, clamp t to one and form the four dot-product terms.
	logic             vld_s1;
	logic [3:0][15:0] st_s1, fin_s1;
	logic [15:0]      frac_s1;
	logic [3:0][31:0] prod_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 4; i++) begin
				st_s1[i]   <= s_tdata[16*i +: 16];
				fin_s1[i]  <= s_tdata[64+16*i +: 16];
				prod_s1[i] <= $signed(s_tdata[16*i +: 16]) * $signed(s_tdata[64+16*i +: 16]);
			end
			frac_s1 <= (s_tdata[143:128] > FRAC_ONE) ? FRAC_ONE : s_tdata[143:128];
		end
	end

	// Stage 2: sum the dot product, decide whether the start is simply copied, fold the
	// end quaternion onto the near hemisphere (all four components) and prepare the fallback
	// used when the spherical blend is not: the start itself when copied, otherwise the mean.
	logic signed [33:0] dot;
	logic [33:0]        dmag;
	logic               big, neg;
	item_t              it_n2;

	always_comb begin
		logic signed [16:0] ev;
		logic signed [17:0] sm;
		dot  = 34'($signed(prod_s1[0])) + 34'($signed(prod_s1[1]))
			 + 34'($signed(prod_s1[2])) + 34'($signed(prod_s1[3]));
		big  = (dot >= DOT_ONE) || (dot <= -DOT_ONE);
		neg  = dot[33];
		dmag = neg ? -dot : dot;
		it_n2.st      = st_s1;
		it_n2.frac    = frac_s1;
		it_n2.big     = big;
		it_n2.fb_path = big ? PATH_COPY : PATH_MEAN;
		for (int i = 0; i < 4; i++) begin
			ev = 17'($signed(fin_s1[i]));
			if (neg) begin
				ev = -ev;
			end
			sm = 18'($signed(st_s1[i])) + 18'(ev);
			it_n2.fin[i] = ev;
			it_n2.fb[i]  = big ? st_s1[i] : sat16(24'(sm >>> 1));
		end
	end

	logic        vld_s2;
	logic [27:0] c_s2;
	item_t       it_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			c_s2  <= dmag[27:0];
			it_s2 <= it_n2;
		end
	end

	// Stage 3: one minus the squared cosine feeds the square root.
	logic [55:0] cc;
	logic        vld_s3;
	logic [28:0] rad_s3;
	sq_sb_t      sq_sb_s3;

	assign cc = 56'(c_s2) * 56'(c_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rad_s3      <= ONE_Q28 - {1'b0, cc[55:28]};
			sq_sb_s3.c  <= c_s2;
			sq_sb_s3.it <= it_s2;
		end
	end

	logic        sq_vld;
	logic [28:0] sq_root;
	sq_sb_t      sq_sb_o;

	qslerp_sqrt #(
		.SB_W ($bits(sq_sb_t))
	) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (vld_s3),
		.rad       (rad_s3),
		.sb_in     (sq_sb_s3),
		.out_valid (sq_vld),
		.root      (sq_root),
		.sb_out    (sq_sb_o)
	);

	// Stage 4: compare the half-angle sine against the small-angle threshold.
	logic        vld_s4;
	logic [28:0] sn_s4;
	logic [27:0] c_s4;
	vec_sb_t     vsb_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s4 <= sq_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sn_s4            <= sq_root;
			c_s4             <= sq_sb_o.c;
			vsb_s4.it        <= sq_sb_o.it;
			vsb_s4.try_blend <= !sq_sb_o.it.big && (sq_root >= {lim_q, 14'b0});
		end
	end

	logic               vec_vld;
	logic signed [31:0] vec_ang;
	vec_sb_t            vec_sb_o;

	qslerp_cordic_vec #(
		.N    (TRIG_ITERATIONS),
		.SB_W ($bits(vec_sb_t))
	) u_vec (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (vld_s4),
		.x_in      ($signed({4'b0, c_s4})),
		.y_in      ($signed({3'b0, sn_s4})),
		.sb_in     (vsb_s4),
		.out_valid (vec_vld),
		.ang_out   (vec_ang),
		.sb_out    (vec_sb_o)
	);

	// Stage 5: clamp the half angle to the first quadrant.
	logic        vld_s5;
	logic [30:0] th_s5;
	vec_sb_t     vsb_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (adv) begin
			vld_s5 <= vec_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			vsb_s5 <= vec_sb_o;
			if (vec_ang < 0) begin
				th_s5 <= '0;
			end else if (vec_ang > HALF_PI_Q30) begin
				th_s5 <= HALF_PI_Q30[30:0];
			end else begin
				th_s5 <= vec_ang[30:0];
			end
		end
	end

	// Stage 6: split the half angle by t into the two blend angles.
	logic [46:0]        pa, pb;
	logic               vld_s6;
	logic signed [31:0] ang_s6 [3];
	vec_sb_t            vsb_s6;

	assign pa = 47'(th_s5) * 47'(FRAC_ONE - vsb_s5.it.frac);
	assign pb = 47'(th_s5) * 47'(vsb_s5.it.frac);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else if (adv) begin
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ang_s6[0] <= $signed({1'b0, th_s5});
			ang_s6[1] <= $signed({1'b0, pa[45:15]});
			ang_s6[2] <= $signed({1'b0, pb[45:15]});
			vsb_s6    <= vsb_s5;
		end
	end

	logic               rot_vld;
	logic signed [31:0] rot_sin [3];
	vec_sb_t            rot_sb_o;

	qslerp_cordic_rot #(
		.N     (TRIG_ITERATIONS),
		.LANES (3),
		.SB_W  ($bits(vec_sb_t))
	) u_rot (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (vld_s6),
		.ang_in    (ang_s6),
		.sb_in     (vsb_s6),
		.out_valid (rot_vld),
		.sin_out   (rot_sin),
		.sb_out    (rot_sb_o)
	);

	// Stage 7: the blend is taken only when the denominator sine is positive. The
	// numerators go to the divider as magnitude and sign, giving truncation toward zero.
	logic        vld_s7;
	logic [28:0] den_s7;
	logic [28:0] mag_s7 [2];
	div_sb_t     dsb_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
		end else if (adv) begin
			vld_s7 <= rot_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			den_s7       <= rot_sin[0][28:0];
			dsb_s7.it    <= rot_sb_o.it;
			dsb_s7.blend <= rot_sb_o.try_blend && (rot_sin[0] > 0);
			for (int l = 0; l < 2; l++) begin
				dsb_s7.neg[l] <= rot_sin[l+1][31];
				mag_s7[l]     <= rot_sin[l+1][31] ? 29'(-rot_sin[l+1]) : rot_sin[l+1][28:0];
			end
		end
	end

	logic        div_vld;
	logic [33:0] div_quo [2];
	logic        div_ovf [2];
	div_sb_t     div_sb_o;

	qslerp_div #(
		.LANES (2),
		.SB_W  ($bits(div_sb_t))
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (vld_s7),
		.num_in    (mag_s7),
		.den_in    (den_s7),
		.sb_in     (dsb_s7),
		.out_valid (div_vld),
		.quo_out   (div_quo),
		.ovf_out   (div_ovf),
		.sb_out    (div_sb_o)
	);

	// Stage 8: saturate the ratios to plus or minus 2^32 and restore their signs.
	logic               vld_s8;
	logic signed [33:0] rat_s8 [2];
	div_sb_t            dsb_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s8 <= 1'b0;
		end else if (adv) begin
			vld_s8 <= div_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			logic [33:0] mag;
			dsb_s8 <= div_sb_o;
			for (int l = 0; l < 2; l++) begin
				mag = (div_ovf[l] || (div_quo[l] > RATIO_LIM)) ? RATIO_LIM : div_quo[l];
				rat_s8[l] <= div_sb_o.neg[l] ? -$signed(mag) : $signed(mag);
			end
		end
	end

	// Stage 9: weight each start and end component by its ratio.
	logic               vld_s9;
	logic signed [49:0] ps_s9 [4];
	logic signed [50:0] pe_s9 [4];
	div_sb_t            dsb_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s9 <= 1'b0;
		end else if (adv) begin
			vld_s9 <= vld_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dsb_s9 <= dsb_s8;
			for (int i = 0; i < 4; i++) begin
				ps_s9[i] <= 50'($signed(dsb_s8.it.st[i])) * 50'(rat_s8[0]);
				pe_s9[i] <= 51'($signed(dsb_s8.it.fin[i])) * 51'(rat_s8[1]);
			end
		end
	end

	// Output register: round, scale back to Q2.14 and saturate, or pass the fallback.
	logic             out_vld_q;
	logic [3:0][15:0] res_q;
	path_t            path_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= vld_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			logic signed [51:0] acc;
			if (dsb_s9.blend) begin
				path_q <= PATH_BLEND;
				for (int i = 0; i < 4; i++) begin
					acc = 52'(ps_s9[i]) + 52'(pe_s9[i]) + ROUND_Q27;
					res_q[i] <= sat16(acc[51:28]);
				end
			end else begin
				path_q <= dsb_s9.it.fb_path;
				res_q  <= dsb_s9.it.fb;
			end
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = res_q;
	assign m_tuser  = path_q;

`ifndef SYNTHESIS
	// The square root of a value no larger than 2^56 never exceeds one.
	a_sine_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s4 |-> sn_s4 <= ONE_Q28)
		else $error("half-angle sine above one");

	// The two blend angles are floors of complementary fractions of the half angle.
	a_angle_split: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s6 |-> (33'(ang_s6[1]) + 33'(ang_s6[2])) <= 33'(ang_s6[0]))
		else $error("blend angles exceed the half angle");

	// The divider is never asked to divide by zero for a blended item.
	a_den_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s7 && dsb_s7.blend) |-> den_s7 != '0)
		else $error("blend selected with zero denominator");

	// A stalled pipe keeps its items in place.
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s9 && !adv) |=> vld_s9 && out_vld_q)
		else $error("item lost during stall");
`endif

endmodule

// ----- test/tb_quaternion_slerp_unit.sv -----
// Self-checking testbench for quaternion_slerp_unit: directed table then random blends.
// Holds its own fixed-point slerp predictor; depends on qslerp_pkg and the unit itself.
module tb_quaternion_slerp_unit;
	import qslerp_pkg::*;

	localparam int ITERS = 16;
	localparam int LATENCY = 73 + 2 * ITERS;

	// Arctangent steps in Q.30 radians, one per CORDIC iteration.
	localparam longint ATAN_STEP [0:15] = '{
		64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
		64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
		64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
		64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF};
	localparam longint Q28 = 64'h1000_0000;
	localparam longint HALF_PI = 64'd1686629713;
	localparam longint RLIM = 64'h1_0000_0000;

	typedef struct packed {
		logic [15:0] frac;
		logic [3:0][15:0] fin;
		logic [3:0][15:0] st;
	} request_t;

	typedef struct packed {
		path_t path;
		logic [3:0][15:0] q;
	} blend_t;

	logic clk = 0, arst_n = 0;
	logic s_tvalid = 0, s_tready, m_tvalid, m_tready = 0;
	logic [143:0] s_tdata = '0;
	logic [63:0] m_tdata;
	logic [1:0] m_tuser;
	logic cfg_valid = 0, cfg_ready;
	logic [14:0] cfg_data = '0;

	quaternion_slerp_unit #(.TRIG_ITERATIONS(ITERS)) DUT (.*);

	initial forever #6 clk = ~clk;

	initial begin
		#12_000_000;
		$display("Some tests failed");
		$finish;
	end

	blend_t expected_q[$];
	int errors = 0, results_seen = 0, mean_seen = 0, copy_seen = 0, sphere_seen = 0;
	int send_idle = 0, recv_stall = 0, hold_off = 0;
	logic [14:0] angle_limit = 16;

	function automatic longint shr(longint v, int k);
		return v >>> k;
	endfunction

	function automatic longint clip16(longint v);
		return v > 32767 ? 32767 : (v < -32768 ? -32768 : v);
	endfunction

	function automatic longint root_q28(longint v);
		longint r = 0, c;
		for (int b = 28; b >= 0; b--) begin
			c = r | (64'd1 << b);
			if (c * c <= v) r = c;
		end
		return r;
	endfunction

	function automatic longint half_angle(longint x, longint y);
		longint z = 0, dx, dy;
		for (int i = 0; i < ITERS; i++) begin
			dx = shr(y, i);
			dy = shr(x, i);
			if (y > 0) begin
				x += dx; y -= dy; z += ATAN_STEP[i];
			end else begin
				x -= dx; y += dy; z -= ATAN_STEP[i];
			end
		end
		if (z < 0) z = 0;
		if (z > HALF_PI) z = HALF_PI;
		return z;
	endfunction

	function automatic longint rotated_sine(longint z);
		longint x = Q28, y = 0, dx, dy;
		for (int i = 0; i < ITERS; i++) begin
			dx = shr(y, i);
			dy = shr(x, i);
			if (z >= 0) begin
				x -= dx; y += dy; z -= ATAN_STEP[i];
			end else begin
				x += dx; y -= dy; z += ATAN_STEP[i];
			end
		end
		return y;
	endfunction

	function automatic longint weight(longint num, longint den);
		longint r = (num * Q28) / den;
		return r > RLIM ? RLIM : (r < -RLIM ? -RLIM : r);
	endfunction

	function automatic blend_t slerp_predict(request_t rq);
		longint s[4], e[4], d = 0, c, sn, th, den, a, b, ra, rb, t;
		blend_t r;
		t = rq.frac > 16'h8000 ? 64'd32768 : longint'(rq.frac);
		for (int i = 0; i < 4; i++) begin
			s[i] = longint'($signed(rq.st[i]));
			e[i] = longint'($signed(rq.fin[i]));
			d += s[i] * e[i];
		end
		if (d >= Q28 || d <= -Q28) begin
			r.path = PATH_COPY;
			for (int i = 0; i < 4; i++) r.q[i] = rq.st[i];
			return r;
		end
		if (d < 0) begin
			d = -d;
			for (int i = 0; i < 4; i++) e[i] = -e[i];
		end
		c = d;
		sn = root_q28((Q28 - ((c * c) >>> 28)) << 28);
		r.path = PATH_MEAN;
		if (sn >= (longint'(angle_limit) << 14)) begin
			th = half_angle(c, sn);
			den = rotated_sine(th);
			if (den > 0) begin
				a = (th * (32768 - t)) >>> 15;
				b = (th * t) >>> 15;
				ra = weight(rotated_sine(a), den);
				rb = weight(rotated_sine(b), den);
				r.path = PATH_BLEND;
				for (int i = 0; i < 4; i++)
					r.q[i] = 16'(clip16(shr(s[i] * ra + e[i] * rb + (64'd1 << 27), 28)));
			end
		end
		if (r.path == PATH_MEAN)
			for (int i = 0; i < 4; i++) r.q[i] = 16'(clip16(shr(s[i] + e[i], 1)));
		return r;
	endfunction

	// Receiver: stalls at the configured rate, or holds off entirely for a counted stretch.
	always @(negedge clk) begin
		if (hold_off > 0) begin
			m_tready <= 1'b0;
			hold_off <= hold_off - 1;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall);
		end
	end

	always @(posedge clk) begin
		blend_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got.q = m_tdata;
			got.path = path_t'(m_tuser);
			results_seen++;
			if (expected_q.size() == 0) begin
				$display("%0t: result with none expected: %h", $time, got);
				errors++;
			end else begin
				want = expected_q.pop_front();
				case (got.path)
					PATH_COPY: copy_seen++;
					PATH_MEAN: mean_seen++;
					default: sphere_seen++;
				endcase
				if (got.path !== want.path) begin
					$display("%0t: path expected %0d actual %0d", $time, want.path, got.path);
					errors++;
				end
				for (int i = 0; i < 4; i++)
					if (got.q[i] !== want.q[i]) begin
						$display("%0t: component %0d expected %h actual %h",
							$time, i, want.q[i], got.q[i]);
						errors++;
					end
			end
		end
	end

	// Valid stays high between back-to-back items and drops only for idle cycles.
	task automatic send_item(request_t rq);
		while (send_idle > 0 && $urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tdata <= {rq.frac, rq.fin, rq.st};
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		expected_q.push_back(slerp_predict(rq));
		@(negedge clk);
	endtask

	// Known answers, checked against the table as well as the predictor.
	task automatic send_checked(request_t rq, blend_t known);
		if (slerp_predict(rq) !== known) begin
			$display("%0t: table expected %h, predictor gives %h", $time, known, slerp_predict(rq));
			errors++;
		end
		send_item(rq);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (expected_q.size() > 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_limit(logic [14:0] v);
		cfg_data <= v;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		angle_limit = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [15:0] rand_comp(int mode);
		case (mode)
			0: return 16'($urandom);
			1: return 16'($signed($urandom_range(16384)) - 8192);
			default: return 16'($urandom_range(8192) - 4096);
		endcase
	endfunction

	// Mostly unit-ish quaternions so the blend path is reached; ends close together at times.
	function automatic request_t rand_request();
		request_t rq;
		int mode = $urandom_range(9) < 2 ? 0 : 1;
		for (int i = 0; i < 4; i++) rq.st[i] = rand_comp(mode);
		for (int i = 0; i < 4; i++)
			rq.fin[i] = ($urandom_range(4) == 0) ? rq.st[i] + 16'($urandom_range(8) - 4)
				: rand_comp(mode);
		rq.frac = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(32768));
		return rq;
	endfunction

	localparam int TABLE_ROWS = 14;
	// Each row: start, end, fraction, and whether a known answer is typed in.
	typedef struct {
		request_t rq;
		bit known;
		blend_t ans;
	} row_t;

	row_t directed[TABLE_ROWS];

	initial begin
		int phase_stall [4] = '{0, 0, 80, 21};
		int phase_idle [4] = '{0, 80, 0, 21};
		logic [14:0] limits [4] = '{15'd0, 15'h7FFF, 15'd16384, 15'd800};
		request_t rq;
		// Identity against itself: dot product exactly one, start is copied.
		directed[0] = '{'{16'h4000, {16'h0, 16'h0, 16'h0, 16'h4000},
			{16'h0, 16'h0, 16'h0, 16'h4000}},
			1, '{PATH_COPY, {16'h0, 16'h0, 16'h0, 16'h4000}}};
		// Opposite identities: dot product minus one, start still copied.
		directed[1] = '{'{16'h0, {16'h0, 16'h0, 16'h0, 16'hC000},
			{16'h0, 16'h0, 16'h0, 16'h4000}}, 1,
			'{PATH_COPY, {16'h0, 16'h0, 16'h0, 16'h4000}}};
		// All-zero quaternions: sine is one, blend of zeros is zero.
		directed[2] = '{'{16'h4000, '0, '0}, 1, '{PATH_BLEND, '0}};
		// Extreme components: huge dot product, copied.
		directed[3] = '{'{16'hFFFF, {4{16'h8000}}, {4{16'h8000}}}, 1,
			'{PATH_COPY, {4{16'h8000}}}};
		directed[4] = '{'{16'h0, {4{16'h7FFF}}, {4{16'h8000}}}, 1,
			'{PATH_COPY, {4{16'h8000}}}};
		// Orthogonal unit quaternions at t = 0, one half, one and above one.
		directed[5] = '{'{16'h0, {16'h0, 16'h0, 16'h4000, 16'h0}, {16'h0, 16'h0, 16'h0, 16'h4000}},
			0, '{PATH_COPY, '0}};
		directed[6] = directed[5]; directed[6].rq.frac = 16'h4000;
		directed[7] = directed[5]; directed[7].rq.frac = 16'h8000;
		directed[8] = directed[5]; directed[8].rq.frac = 16'hFFFF;
		// Negative dot product: end is flipped, z component included.
		directed[9] = '{'{16'h2000, {16'hD000, 16'h1000, 16'h0, 16'h1000},
			{16'h2000, 16'h0, 16'h1000, 16'h3000}}, 0, '{PATH_COPY, '0}};
		// Nearly equal quaternions: small sine, yet above the default small-angle limit, so blended.
		directed[10] = '{'{16'h4000, {16'h0, 16'h0, 16'h1, 16'h3FFF},
			{16'h0, 16'h0, 16'h0, 16'h4000}}, 0, '{PATH_COPY, '0}};
		// Large opposite-signed end components against a zero start: dot product zero, so blended.
		directed[11] = '{'{16'h1234, {16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000}, '0}, 0,
			'{PATH_COPY, '0}};
		directed[12] = '{'{16'h0, {16'h0, 16'h0, 16'h0, 16'h2D41}, {16'h0, 16'h0, 16'h2D41, 16'h0}},
			0, '{PATH_COPY, '0}};
		directed[13] = '{'{16'h7FFF, {16'hFFFF, 16'h0, 16'h0, 16'h0},
			{16'hFFFF, 16'h0, 16'h0, 16'h0}}, 0, '{PATH_COPY, '0}};

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		foreach (directed[r])
			if (directed[r].known) send_checked(directed[r].rq, directed[r].ans);
			else send_item(directed[r].rq);
		drain();

		for (int p = 0; p < 4; p++) begin
			write_limit(limits[p]);
			send_idle = phase_idle[p];
			recv_stall = phase_stall[p];
			if (p == 0) hold_off = 400;
			for (int n = 0; n < 200; n++) begin
				rq = rand_request();
				send_item(rq);
			end
			drain();
		end
		write_limit(15'd16);
		recv_stall = 0;

		$display("Ran %0d results: %0d copied, %0d mean, %0d spherical, over four limits.",
			results_seen, copy_seen, mean_seen, sphere_seen);
		if (errors == 0 && expected_q.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
